>>> design/lzdict_pkg.sv
`default_nettype none

package lzdict_pkg;

   localparam int CODE_W        = 13;
   localparam int LIMIT_W       = 13;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 13;
   localparam int MAX_SLOTS_DEF = 4096;
   localparam int ALPHABET_DEF  = 256;

   localparam logic [LIMIT_W-1:0] DICT_LIMIT_RST = 13'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DICT_LIMIT  = 1'b0,
      CSR_SINGLE_CHAR = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> design/lz_dict_prefix_lru_replace_core.sv
// LZ78 dictionary slot manager with least-recently-used slot replacement. Raise start with
// req_matched_index while busy is low; exactly one result beat follows on rsp_valid, which
// strobes for a single cycle and cannot be held off, so sample it when it appears. An index
// above the current entry count gives a zero result in the cycle after the start. Otherwise
// the item walks the parent chain in three parent/prev/next memories (single registered read
// port): a queued chain entry that is already most recent needs only the WALK state, any
// other is moved to the tail through WALK, W2 and W3 (one read plus three link writes sharing
// the next-link memory port); the slot choice and splice then run through ALLOC, RM when a
// slot is recycled, INS and PT2 or IB and IB2, or ALLOC alone when nothing is added,
// and busy drops in the cycle the result strobes. csr_ready is low while busy or while start
// is high. Writing either control register reinitializes the dictionary in the same cycle; no
// clearing pass is needed since queue membership follows from the entry count.
`default_nettype none

module lz_dict_prefix_lru_replace_core
   import lzdict_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int ALPHABET  = ALPHABET_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [CODE_W-1:0]     req_matched_index,
   output logic                       rsp_valid,
   output logic [CODE_W-1:0]          rsp_new_codeword,
   output logic                       rsp_was_recycled,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = $clog2(MAX_SLOTS + 2);
   localparam int CW = (IW > CODE_W) ? IW : CODE_W;
   localparam logic [IW-1:0] QNIL     = IW'(MAX_SLOTS + 1);
   localparam logic [IW-1:0] SLOT_MAX = IW'(MAX_SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_W2,
      ST_W3,
      ST_ALLOC,
      ST_RM,
      ST_INS,
      ST_IB,
      ST_IB2,
      ST_PT2
   } state_type;

   state_type           state_ff, state_in;
   logic [IW-1:0]       entry_count_ff, entry_count_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [LIMIT_W-1:0]  dict_limit_ff, dict_limit_in;
   logic                single_ff, single_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic                rsp_rec_ff, rsp_rec_in;
   logic [IW-1:0]       m_ff, m_in;
   logic [IW-1:0]       j_ff, j_in;
   logic [IW-1:0]       p_ff, p_in;
   logic [IW-1:0]       par_ff, par_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic                rec_ff, rec_in;

   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       par_rd, prv_rd, nxt_rd;
   logic                pw_en, vw_en, nw_en;
   logic [IW-1:0]       pw_addr, vw_addr, nw_addr;
   logic [IW-1:0]       pw_data, vw_data, nw_data;

   logic [CW-1:0]       lim;
   logic                walk_end;
   logic [IW-1:0]       nj;

   function automatic logic is_queued(input logic [IW-1:0] x, input logic [IW-1:0] cnt,
                                      input logic single);
      is_queued = (x != '0) && (x <= cnt) && !(single && (x <= IW'(ALPHABET)));
   endfunction

   function automatic logic ok_slot(input logic [IW-1:0] x);
      ok_slot = (x <= SLOT_MAX);
   endfunction

   lzdict_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS + 1), .ADDR_W(IW)) u_parent_ram (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (pw_addr),
      .wr_data (pw_data),
      .rd_addr (rd_addr),
      .rd_data (par_rd)
   );

   lzdict_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS + 1), .ADDR_W(IW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (vw_en),
      .wr_addr (vw_addr),
      .wr_data (vw_data),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   lzdict_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS + 1), .ADDR_W(IW)) u_next_ram (
      .clock   (clock),
      .wr_en   (nw_en),
      .wr_addr (nw_addr),
      .wr_data (nw_data),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE) && !start;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_codeword = rsp_code_ff;
   assign rsp_was_recycled = rsp_rec_ff;

   always_comb begin
      if (dict_limit_ff == '0) begin
         lim = CW'(1);
      end else if (CW'(dict_limit_ff) > CW'(MAX_SLOTS)) begin
         lim = CW'(MAX_SLOTS);
      end else begin
         lim = CW'(dict_limit_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      dict_limit_in  = dict_limit_ff;
      single_in      = single_ff;
      rsp_valid_in   = 1'b0;
      rsp_code_in    = rsp_code_ff;
      rsp_rec_in     = rsp_rec_ff;
      m_in           = m_ff;
      j_in           = j_ff;
      p_in           = p_ff;
      par_in         = par_ff;
      cnt_in         = cnt_ff;
      slot_in        = slot_ff;
      rec_in         = rec_ff;
      rd_addr        = j_ff;
      pw_en          = 1'b0;
      pw_addr        = slot_ff;
      pw_data        = m_ff;
      vw_en          = 1'b0;
      vw_addr        = slot_ff;
      vw_data        = QNIL;
      nw_en          = 1'b0;
      nw_addr        = slot_ff;
      nw_data        = QNIL;
      walk_end       = 1'b0;
      nj             = j_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               case (csr_index_type'(csr_index))
                  CSR_DICT_LIMIT:  dict_limit_in = LIMIT_W'(csr_wdata);
                  CSR_SINGLE_CHAR: single_in = csr_wdata[0];
                  default:         single_in = single_ff;
               endcase
               entry_count_in = single_in ? IW'(ALPHABET) : '0;
               head_in        = QNIL;
               tail_in        = QNIL;
            end
            if (start) begin
               if (CW'(req_matched_index) > CW'(entry_count_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = '0;
                  rsp_rec_in   = 1'b0;
               end else begin
                  m_in   = IW'(req_matched_index);
                  j_in   = IW'(req_matched_index);
                  cnt_in = '0;
                  if (is_queued(m_in, entry_count_ff, single_ff)) begin
                     rd_addr  = m_in;
                     state_in = ST_WALK;
                  end else begin
                     state_in = ST_ALLOC;
                  end
               end
            end
         end
         ST_WALK: begin
            if (j_ff == tail_ff) begin
               walk_end = 1'b1;
               nj       = par_rd;
            end else begin
               // unlink j: next[prev] or head, prev[next]
               if (ok_slot(prv_rd)) begin
                  nw_en   = 1'b1;
                  nw_addr = prv_rd;
                  nw_data = nxt_rd;
               end else begin
                  head_in = nxt_rd;
               end
               vw_en    = 1'b1;
               vw_addr  = nxt_rd;
               vw_data  = prv_rd;
               par_in   = par_rd;
               state_in = ST_W2;
            end
         end
         ST_W2: begin
            nw_en    = 1'b1;
            nw_addr  = tail_ff;
            nw_data  = j_ff;
            vw_en    = 1'b1;
            vw_addr  = j_ff;
            vw_data  = tail_ff;
            tail_in  = j_ff;
            state_in = ST_W3;
         end
         ST_W3: begin
            nw_en    = 1'b1;
            nw_addr  = j_ff;
            nw_data  = QNIL;
            walk_end = 1'b1;
            nj       = par_ff;
         end
         ST_ALLOC: begin
            if (CW'(entry_count_ff) < lim) begin
               entry_count_in = entry_count_ff + 1'b1;
               slot_in        = entry_count_ff + 1'b1;
               rec_in         = 1'b0;
               state_in       = ST_INS;
            end else if ((head_ff == QNIL) || (head_ff == m_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = '0;
               rsp_rec_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               slot_in  = head_ff;
               rec_in   = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_RM;
            end
         end
         ST_RM: begin
            head_in = nxt_rd;
            if (ok_slot(nxt_rd)) begin
               vw_en   = 1'b1;
               vw_addr = nxt_rd;
               vw_data = QNIL;
            end else begin
               tail_in = QNIL;
            end
            state_in = ST_INS;
         end
         ST_INS: begin
            pw_en   = 1'b1;
            pw_addr = slot_ff;
            pw_data = m_ff;
            if (is_queued(m_ff, entry_count_ff, single_ff)) begin
               rd_addr  = m_ff;
               state_in = ST_IB;
            end else begin
               vw_en   = 1'b1;
               vw_addr = slot_ff;
               vw_data = tail_ff;
               if (ok_slot(tail_ff)) begin
                  nw_en   = 1'b1;
                  nw_addr = tail_ff;
                  nw_data = slot_ff;
               end else begin
                  head_in = slot_ff;
               end
               state_in = ST_PT2;
            end
         end
         ST_PT2: begin
            nw_en        = 1'b1;
            nw_addr      = slot_ff;
            nw_data      = QNIL;
            tail_in      = slot_ff;
            rsp_valid_in = 1'b1;
            rsp_code_in  = CODE_W'(slot_ff);
            rsp_rec_in   = rec_ff;
            state_in     = ST_IDLE;
         end
         ST_IB: begin
            vw_en    = 1'b1;
            vw_addr  = slot_ff;
            vw_data  = prv_rd;
            nw_en    = 1'b1;
            nw_addr  = slot_ff;
            nw_data  = m_ff;
            p_in     = prv_rd;
            state_in = ST_IB2;
         end
         ST_IB2: begin
            vw_en   = 1'b1;
            vw_addr = m_ff;
            vw_data = slot_ff;
            if (ok_slot(p_ff)) begin
               nw_en   = 1'b1;
               nw_addr = p_ff;
               nw_data = slot_ff;
            end else begin
               head_in = slot_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_code_in  = CODE_W'(slot_ff);
            rsp_rec_in   = rec_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next chain entry, bounded step count
      if (walk_end) begin
         cnt_in = cnt_ff + 1'b1;
         j_in   = nj;
         if ((cnt_in <= SLOT_MAX) && is_queued(nj, entry_count_ff, single_ff)) begin
            rd_addr  = nj;
            state_in = ST_WALK;
         end else begin
            state_in = ST_ALLOC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         head_ff        <= QNIL;
         tail_ff        <= QNIL;
         dict_limit_ff  <= DICT_LIMIT_RST;
         single_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         dict_limit_ff  <= dict_limit_in;
         single_ff      <= single_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_rec_ff  <= rsp_rec_in;
      m_ff        <= m_in;
      j_ff        <= j_in;
      p_ff        <= p_in;
      par_ff      <= par_in;
      cnt_ff      <= cnt_in;
      slot_ff     <= slot_in;
      rec_ff      <= rec_in;
   end

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_slot_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> ((slot_ff != m_ff) && (slot_ff != '0) && (slot_ff <= SLOT_MAX)))
      else $error("bad slot chosen for insertion");

   a_next_wr_addr: assert property (@(posedge clock) disable iff (reset)
      nw_en |-> (nw_addr <= SLOT_MAX))
      else $error("next-link write to empty marker");

   a_prev_wr_addr: assert property (@(posedge clock) disable iff (reset)
      vw_en |-> (vw_addr <= SLOT_MAX))
      else $error("prev-link write to empty marker");
`endif

endmodule

`default_nettype wire

>>> design/lzdict_ram.sv
`default_nettype none

module lzdict_ram #(
   parameter int WIDTH  = 13,
   parameter int DEPTH  = 4097,
   parameter int ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      rd_data <= mem[rd_addr[AW-1:0]];
   end

endmodule

`default_nettype wire

>>> tb/lz_dict_prefix_lru_replace_core_test.sv
module lz_dict_prefix_lru_replace_core_test
   import lzdict_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_MAX    = MAX_SLOTS_DEF;
   localparam int SLOT_NIL    = MAX_SLOTS_DEF + 1;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              recycled;
   } slot_result_type;

   class slot_scoreboard_type;
      int unsigned      limit_reg;
      int unsigned      single_mode;
      int unsigned      entry_count;
      int unsigned      parent[SLOT_MAX+1];
      int unsigned      prv[SLOT_MAX+1];
      int unsigned      nxt[SLOT_MAX+1];
      bit               queued[SLOT_MAX+1];
      int unsigned      head;
      int unsigned      tail;
      int unsigned      last_code;
      slot_result_type  expected_slots[$];
      int               errors;
      int               accepted;
      int               checked;
      int               recycled_seen;
      int               empty_seen;
      int               reg_writes;

      function new();
         limit_reg   = 4096;
         single_mode = 0;
         clear_dict();
      endfunction

      function bit in_range(int unsigned s);
         return s <= SLOT_MAX;
      endfunction

      function void clear_dict();
         for (int i = 0; i <= SLOT_MAX; i++) begin
            parent[i] = 0;
            prv[i]    = 0;
            nxt[i]    = 0;
            queued[i] = 0;
         end
         head        = SLOT_NIL;
         tail        = SLOT_NIL;
         last_code   = 0;
         entry_count = single_mode ? ALPHABET_DEF : 0;
      endfunction

      function void unlink(int unsigned s);
         int unsigned p;
         int unsigned n;
         if (!in_range(s) || !queued[s]) return;
         p = prv[s];
         n = nxt[s];
         if (in_range(p)) nxt[p] = n; else head = n;
         if (in_range(n)) prv[n] = p; else tail = p;
         queued[s] = 0;
      endfunction

      function void append(int unsigned s);
         prv[s] = tail;
         nxt[s] = SLOT_NIL;
         if (in_range(tail)) nxt[tail] = s; else head = s;
         tail      = s;
         queued[s] = 1;
      endfunction

      function void link_before(int unsigned s, int unsigned k);
         int unsigned p;
         p      = prv[k];
         prv[s] = p;
         nxt[s] = k;
         prv[k] = s;
         if (in_range(p)) nxt[p] = s; else head = s;
         queued[s] = 1;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         case (idx)
            CSR_DICT_LIMIT:  limit_reg = 32'(data);
            CSR_SINGLE_CHAR: single_mode = 32'(data[0]);
            default: ;
         endcase
         clear_dict();
      endfunction

      function void note_match(logic [CODE_W-1:0] match);
         slot_result_type r;
         int unsigned     m;
         int unsigned     j;
         int unsigned     slot;
         int unsigned     lim;
         bit              from_head;
         int              guard;
         r         = '0;
         m         = 32'(match);
         from_head = 0;
         accepted++;
         if (m <= entry_count && in_range(m)) begin
            // refresh the prefix chain up to the root or a permanent entry
            j     = m;
            guard = 0;
            while (guard <= SLOT_MAX && in_range(j) && queued[j]) begin
               unlink(j);
               append(j);
               j = parent[j];
               guard++;
            end
            lim = limit_reg == 0 ? 1 : (limit_reg > SLOT_MAX ? SLOT_MAX : limit_reg);
            if (entry_count < lim) begin
               entry_count++;
               slot = entry_count;
            end else begin
               slot      = head;
               from_head = 1;
            end
            if (in_range(slot) && slot != m) begin
               unlink(slot);
               if (queued[m]) link_before(slot, m);
               else append(slot);
               parent[slot] = m;
               r.code       = CODE_W'(slot);
               r.recycled   = from_head;
               last_code    = slot;
            end
         end
         expected_slots = {expected_slots, r};
      endfunction

      function logic [CODE_W-1:0] choose_match();
         int unsigned roll;
         roll = $urandom_range(0, 99);
         if (roll < 45 && last_code != 0) return CODE_W'(last_code);
         if (roll < 70) return CODE_W'($urandom_range(0, entry_count));
         if (roll < 78) return '0;
         if (roll < 85) return CODE_W'(entry_count);
         if (roll < 92) return CODE_W'(entry_count + 1);
         return CODE_W'($urandom_range(0, 8191));
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_slot(logic [CODE_W-1:0] code, logic recycled);
         slot_result_type e;
         if (expected_slots.size() == 0) begin
            report($sformatf("result beat with nothing expected, codeword %0d", code));
         end else begin
            e = expected_slots.pop_front();
            checked++;
            if (e.recycled) recycled_seen++;
            if (e.code == 0) empty_seen++;
            if (code !== e.code)
               report($sformatf("result %0d new_codeword got %0d want %0d", checked, code,
                                e.code));
            if (recycled !== e.recycled)
               report($sformatf("result %0d was_recycled got %0b want %0b", checked, recycled,
                                e.recycled));
         end
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic [CODE_W-1:0]     req_matched_index = '0;
   logic                  rsp_valid;
   logic [CODE_W-1:0]     rsp_new_codeword;
   logic                  rsp_was_recycled;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_DICT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   slot_scoreboard_type sb = new();
   int                  cycles = 0;
   bit                  no_gap = 0;

   lz_dict_prefix_lru_replace_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_matched_index (req_matched_index),
      .rsp_valid         (rsp_valid),
      .rsp_new_codeword  (rsp_new_codeword),
      .rsp_was_recycled  (rsp_was_recycled),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_slot(rsp_new_codeword, rsp_was_recycled);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_match(req_matched_index);
      end
   end

   task send_item(input logic [CODE_W-1:0] fixed, input bit pick);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock);
         start <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             <= 1;
      req_matched_index <= pick ? sb.choose_match() : fixed;
      do @(posedge clock); while (busy);
   endtask

   task wait_idle();
      @(negedge clock);
      start <= 0;
      while (sb.expected_slots.size() != 0) @(negedge clock);
   endtask

   task write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      int mode;
      int lim;
      int order;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // defaults after reset, then match beyond the entry count
      send_item(13'd0, 0);
      send_item(13'd0, 0);
      send_item(13'd1, 0);
      send_item(13'd2, 0);
      send_item(13'd3, 0);
      send_item(13'd8191, 0);
      send_item(13'd4096, 0);

      // zero limit acts as one: recycle, then victim equals the match
      wait_idle();
      write_csr(CSR_DICT_LIMIT, 13'd0);
      send_item(13'd0, 0);
      send_item(13'd0, 0);
      send_item(13'd1, 0);
      send_item(13'd2, 0);

      wait_idle();
      write_csr(CSR_DICT_LIMIT, 13'd3);
      send_item(13'd0, 0);
      send_item(13'd1, 0);
      send_item(13'd2, 0);
      send_item(13'd3, 0);
      send_item(13'd0, 0);

      // single-symbol mode full with an empty queue
      wait_idle();
      write_csr(CSR_DICT_LIMIT, 13'd256);
      write_csr(CSR_SINGLE_CHAR, 13'h1ffe | 13'd1);
      send_item(13'd5, 0);
      send_item(13'd256, 0);
      send_item(13'd257, 0);
      send_item(13'd0, 0);

      // limit above the slot count, children of permanent entries
      wait_idle();
      write_csr(CSR_DICT_LIMIT, 13'd8191);
      send_item(13'd256, 0);
      send_item(13'd257, 0);
      send_item(13'd0, 0);
      send_item(13'd258, 0);

      for (int ph = 0; ph < 10; ph++) begin
         wait_idle();
         order = $urandom_range(0, 2);
         mode  = order == 2 ? sb.single_mode : $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0:       lim = 0;
            1:       lim = 4096;
            2:       lim = 8191;
            default: lim = (mode ? ALPHABET_DEF : 0) + $urandom_range(1, 32);
         endcase
         if (order == 1)
            write_csr(CSR_SINGLE_CHAR, {12'($urandom_range(0, 4095)), mode[0]});
         write_csr(CSR_DICT_LIMIT, CSR_DATA_W'(lim));
         if (order == 0)
            write_csr(CSR_SINGLE_CHAR, {12'($urandom_range(0, 4095)), mode[0]});
         repeat (63) begin
            if ($urandom_range(0, 19) == 0) no_gap = !no_gap;
            send_item('0, 1);
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (sb.expected_slots.size() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.expected_slots.size()));
      $display("covered %0d items over %0d register writes: %0d results checked,",
               sb.accepted, sb.reg_writes, sb.checked);
      $display("  %0d recycled slots, %0d empty results", sb.recycled_seen, sb.empty_seen);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/lzdict_pkg.sv
design/lzdict_ram.sv
design/lz_dict_prefix_lru_replace_core.sv
tb/lz_dict_prefix_lru_replace_core_test.sv
